// ===== sv/deq_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// deq_pkg
// types, commands and sizes shared by the double-ended queue
// ----------------------------------------------------------------------------
package deq_pkg;

  localparam int DEPTH   = 64;
  localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int WORD_W  = 32;
  localparam int OCC_W   = 7;
  localparam int CMD_W   = 3;
  localparam int STAT_W  = 2;
  localparam int OUT_W   = WORD_W + STAT_W + OCC_W;
  localparam int OUT_PAD = ((OUT_W + 7) / 8) * 8;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH_BACK  = 3'd0,
    CMD_PUSH_FRONT = 3'd1,
    CMD_POP_BACK   = 3'd2,
    CMD_POP_FRONT  = 3'd3,
    CMD_CREATE     = 3'd4
  } cmd_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef struct packed {
    logic              we;
    logic              re;
    logic [ADDR_W-1:0] waddr;
    logic [ADDR_W-1:0] raddr;
    logic [WORD_W-1:0] wdata;
  } mem_req_t;

  typedef struct packed {
    logic             pop_ok;
    status_t          status;
    logic [OCC_W-1:0] occupancy;
  } res_info_t;

endpackage
`default_nettype wire

// ===== sv/deq_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// deq_ram
// simple dual-port synchronous ram, one write and one registered read port
// ----------------------------------------------------------------------------
module deq_ram #(
  parameter int DW    = 32,
  parameter int AW    = 6,
  parameter int WORDS = 64
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [DW-1:0] wdata,
  input  wire logic          re,
  input  wire logic [AW-1:0] raddr,
  output      logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [WORDS];
  logic [DW-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

// ===== sv/deq_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// deq_ctrl
// front and back pointers and entry count, turns commands into ram accesses
// ----------------------------------------------------------------------------
module deq_ctrl (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       cmd_fire,
  input  wire deq_pkg::cmd_t              cmd,
  input  wire logic [deq_pkg::WORD_W-1:0] value,
  output      deq_pkg::mem_req_t          req,
  output      deq_pkg::res_info_t         info
);

  localparam logic [deq_pkg::ADDR_W-1:0] LAST = deq_pkg::ADDR_W'(deq_pkg::DEPTH - 1);
  localparam logic [deq_pkg::CNT_W-1:0]  FULL = deq_pkg::CNT_W'(deq_pkg::DEPTH);

  logic [deq_pkg::ADDR_W-1:0] front_r, front_nxt;
  logic [deq_pkg::ADDR_W-1:0] back_r, back_nxt;
  logic [deq_pkg::CNT_W-1:0]  cnt_r, cnt_nxt;

  function automatic logic [deq_pkg::ADDR_W-1:0] wrap_inc(input logic [deq_pkg::ADDR_W-1:0] i);
    return (i == LAST) ? '0 : i + 1'b1;
  endfunction

  function automatic logic [deq_pkg::ADDR_W-1:0] wrap_dec(input logic [deq_pkg::ADDR_W-1:0] i);
    return (i == '0) ? LAST : i - 1'b1;
  endfunction

  logic is_full, is_empty;
  assign is_full  = (cnt_r == FULL);
  assign is_empty = (cnt_r == '0);

  always_comb begin
    front_nxt      = front_r;
    back_nxt       = back_r;
    cnt_nxt        = cnt_r;
    req.we         = 1'b0;
    req.re         = 1'b0;
    req.waddr      = back_r;
    req.raddr      = front_r;
    req.wdata      = value;
    info.pop_ok    = 1'b0;
    info.status    = deq_pkg::ST_OK;
    case (cmd)
      deq_pkg::CMD_PUSH_BACK: begin
        if (is_full) begin
          info.status = deq_pkg::ST_FULL;
        end else begin
          req.we    = 1'b1;
          req.waddr = back_r;
          back_nxt  = wrap_inc(back_r);
          cnt_nxt   = cnt_r + 1'b1;
        end
      end
      deq_pkg::CMD_PUSH_FRONT: begin
        if (is_full) begin
          info.status = deq_pkg::ST_FULL;
        end else begin
          front_nxt = wrap_dec(front_r);
          req.we    = 1'b1;
          req.waddr = wrap_dec(front_r);
          cnt_nxt   = cnt_r + 1'b1;
        end
      end
      deq_pkg::CMD_POP_BACK: begin
        if (is_empty) begin
          info.status = deq_pkg::ST_EMPTY;
        end else begin
          back_nxt    = wrap_dec(back_r);
          req.re      = 1'b1;
          req.raddr   = wrap_dec(back_r);
          info.pop_ok = 1'b1;
          cnt_nxt     = cnt_r - 1'b1;
        end
      end
      deq_pkg::CMD_POP_FRONT: begin
        if (is_empty) begin
          info.status = deq_pkg::ST_EMPTY;
        end else begin
          req.re      = 1'b1;
          req.raddr   = front_r;
          front_nxt   = wrap_inc(front_r);
          info.pop_ok = 1'b1;
          cnt_nxt     = cnt_r - 1'b1;
        end
      end
      deq_pkg::CMD_CREATE: begin
        req.we    = 1'b1;
        req.waddr = '0;
        front_nxt = '0;
        back_nxt  = wrap_inc('0);
        cnt_nxt   = deq_pkg::CNT_W'(1);
      end
      default: begin
      end
    endcase
    info.occupancy = deq_pkg::OCC_W'(cnt_nxt);
    if (!cmd_fire) begin
      req.we = 1'b0;
      req.re = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_r <= '0;
      back_r  <= '0;
      cnt_r   <= '0;
    end else if (cmd_fire) begin
      front_r <= front_nxt;
      back_r  <= back_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== sv/double_ended_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// double_ended_queue
// bounded double-ended queue of 32-bit words in a circular ram
// ----------------------------------------------------------------------------
// Each command beat (push back, push front, pop back, pop front, create)
// gives exactly one result beat carrying the popped word, a status and the
// occupancy after the command. One command is taken every cycle while the
// output is not stalled; a result passes through the registered read port
// of the entry ram and then the output register. Pointers and the count live
// in flip-flops, so back-to-back commands on the same entry need no interlock.
// Unused command codes change nothing and return status ok.
module double_ended_queue (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output      logic        in_tready,
  input  wire logic [31:0] in_tdata,   // value[31:0]
  input  wire logic [2:0]  in_tuser,   // command[2:0]
  output      logic        out_tvalid,
  input  wire logic        out_tready,
  output      logic [47:0] out_tdata   // popped_value[31:0], status[33:32],
                                       // occupancy[40:34], zero pad
);

  logic                  in_fire;
  logic                  s1_move;
  logic                  s1_v_r;
  deq_pkg::res_info_t    s1_info_r;
  logic                  out_v_r;
  logic [deq_pkg::OUT_W-1:0] out_data_r;
  deq_pkg::mem_req_t     req;
  deq_pkg::res_info_t    info;
  logic [deq_pkg::WORD_W-1:0] rdata;
  logic [deq_pkg::WORD_W-1:0] popped;

  assign s1_move   = s1_v_r && (!out_v_r || out_tready);
  assign in_tready = !s1_v_r || s1_move;
  assign in_fire   = in_tvalid && in_tready;

  deq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd_fire (in_fire),
    .cmd      (deq_pkg::cmd_t'(in_tuser)),
    .value    (in_tdata),
    .req      (req),
    .info     (info)
  );

  deq_ram #(
    .DW    (deq_pkg::WORD_W),
    .AW    (deq_pkg::ADDR_W),
    .WORDS (deq_pkg::DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (req.we),
    .waddr (req.waddr),
    .wdata (req.wdata),
    .re    (req.re),
    .raddr (req.raddr),
    .rdata (rdata)
  );

  assign popped = s1_info_r.pop_ok ? rdata : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (in_fire) begin
        s1_v_r <= 1'b1;
      end else if (s1_move) begin
        s1_v_r <= 1'b0;
      end
      if (s1_move) begin
        out_v_r <= 1'b1;
      end else if (out_tready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_info_r <= info;
    end
    if (s1_move) begin
      out_data_r <= {s1_info_r.occupancy, s1_info_r.status, popped};
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {{(deq_pkg::OUT_PAD - deq_pkg::OUT_W){1'b0}}, out_data_r};

endmodule
`default_nettype wire
